/* hdl/pnr_pkg.sv */
// ----------------------------------------------------------------------------
// pnr_pkg: shared types and constants for the point/normal XYZ rotator
// Register indexes, pipeline depth and the stage-advance control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pnr_pkg;

	localparam int NUM_AXES   = 3;
	localparam int NUM_STAGES = 2 * NUM_AXES;   // multiply + sum stage per axis
	localparam int VEC_LEN    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int AXIS_X     = 0;
	localparam int AXIS_Y     = 1;
	localparam int AXIS_Z     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_EN = 3'd0,
		REG_COS_X   = 3'd1,
		REG_SIN_X   = 3'd2,
		REG_COS_Y   = 3'd3,
		REG_SIN_Y   = 3'd4,
		REG_COS_Z   = 3'd5,
		REG_SIN_Z   = 3'd6
	} pnr_reg_e;

	// per-stage load enables, shared by both lanes
	typedef struct packed {
		logic [NUM_STAGES-1:0] adv;
	} pnr_ctl_t;

endpackage

`default_nettype wire

/* hdl/pnr_ifs.sv */
// ----------------------------------------------------------------------------
// pnr_ifs: channel interfaces of the point/normal XYZ rotator
// Point input channel, rotated point output channel, register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnr_in_if #(
	parameter int COORD_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] nrm_x;
	logic signed [COORD_WIDTH-1:0] nrm_y;
	logic signed [COORD_WIDTH-1:0] nrm_z;
	logic                          last_in;

	modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_in,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_in,
		output ready);
endinterface

interface pnr_out_if #(
	parameter int COORD_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rot_pos_x;
	logic signed [COORD_WIDTH-1:0] rot_pos_y;
	logic signed [COORD_WIDTH-1:0] rot_pos_z;
	logic signed [COORD_WIDTH-1:0] rot_nrm_x;
	logic signed [COORD_WIDTH-1:0] rot_nrm_y;
	logic signed [COORD_WIDTH-1:0] rot_nrm_z;
	logic                          last_out;

	modport source (output valid, rot_pos_x, rot_pos_y, rot_pos_z,
		rot_nrm_x, rot_nrm_y, rot_nrm_z, last_out, input ready);
	modport sink (input valid, rot_pos_x, rot_pos_y, rot_pos_z,
		rot_nrm_x, rot_nrm_y, rot_nrm_z, last_out, output ready);
endinterface

interface pnr_cfg_if import pnr_pkg::*; #(
	parameter int TRIG_WIDTH = 16
) ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [TRIG_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/pnr_lane.sv */
// ----------------------------------------------------------------------------
// pnr_lane: one 3-vector through the X, Y, Z rotation pipeline
// Per axis: a product stage (four multipliers) and a round/sum/saturate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_lane import pnr_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	parameter int TRIG_WIDTH  = 16
) (
	input  wire logic                          clk,
	input  wire pnr_ctl_t                      ctl,
	input  wire logic [NUM_AXES-1:0]           axis_en,
	input  wire logic signed [TRIG_WIDTH-1:0]  cos_v   [NUM_AXES],
	input  wire logic signed [TRIG_WIDTH-1:0]  sin_v   [NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] vec_in  [VEC_LEN],
	output logic signed [COORD_WIDTH-1:0]      vec_out [VEC_LEN]
);

	localparam int FRAC = TRIG_WIDTH - 2;
	localparam int PW   = COORD_WIDTH + TRIG_WIDTH;
	localparam int RW   = PW - FRAC;
	localparam int SW   = RW + 1;
	localparam logic signed [PW-1:0] HALF =
		{{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [COORD_WIDTH-1:0] stage_vec [NUM_AXES+1][VEC_LEN];

	assign stage_vec[0] = vec_in;
	assign vec_out      = stage_vec[NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		// rotated pair (u, v): X -> (y, z), Y -> (z, x), Z -> (x, y)
		localparam int UI = (a == AXIS_X) ? 1 : (a == AXIS_Y) ? 2 : 0;
		localparam int VI = (a == AXIS_X) ? 2 : (a == AXIS_Y) ? 0 : 1;

		// products: 0 u*c, 1 v*s, 2 u*s, 3 v*c
		logic signed [PW-1:0]          prod_s1 [4];
		logic signed [COORD_WIDTH-1:0] keep_s1 [VEC_LEN];
		logic signed [COORD_WIDTH-1:0] vec_s2  [VEC_LEN];
		logic signed [COORD_WIDTH-1:0] nxt_vec [VEC_LEN];
		logic signed [PW-1:0]          rnd_sum [4];
		logic signed [RW-1:0]          rnd     [4];
		logic signed [SW-1:0]          new_u, new_v;
		logic signed [COORD_WIDTH-1:0] sat_u, sat_v;

		always_ff @(posedge clk) begin
			if (ctl.adv[2*a]) begin
				prod_s1[0] <= stage_vec[a][UI] * cos_v[a];
				prod_s1[1] <= stage_vec[a][VI] * sin_v[a];
				prod_s1[2] <= stage_vec[a][UI] * sin_v[a];
				prod_s1[3] <= stage_vec[a][VI] * cos_v[a];
				keep_s1    <= stage_vec[a];
			end
		end

		// round half up: floor((p + 2^(F-1)) / 2^F)
		always_comb begin
			for (int k = 0; k < 4; k++) begin
				rnd_sum[k] = prod_s1[k] + HALF;
				rnd[k]     = rnd_sum[k][PW-1:FRAC];
			end
			new_u = SW'(rnd[0]) - SW'(rnd[1]);
			new_v = SW'(rnd[2]) + SW'(rnd[3]);
			priority if (new_u > SAT_HI) sat_u = SAT_HI[COORD_WIDTH-1:0];
			else if (new_u < SAT_LO)     sat_u = SAT_LO[COORD_WIDTH-1:0];
			else                         sat_u = new_u[COORD_WIDTH-1:0];
			priority if (new_v > SAT_HI) sat_v = SAT_HI[COORD_WIDTH-1:0];
			else if (new_v < SAT_LO)     sat_v = SAT_LO[COORD_WIDTH-1:0];
			else                         sat_v = new_v[COORD_WIDTH-1:0];
			// disabled axis passes the vector through
			nxt_vec = keep_s1;
			if (axis_en[a]) begin
				nxt_vec[UI] = sat_u;
				nxt_vec[VI] = sat_v;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv[2*a+1]) begin
				vec_s2 <= nxt_vec;
			end
		end

		assign stage_vec[a+1] = vec_s2;
	end

endmodule

`default_nettype wire

/* hdl/pnr_merge.sv */
// ----------------------------------------------------------------------------
// pnr_merge: joins the position and normal lanes into one result request
// Output register; frees the last pipeline stage whenever it is empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_merge import pnr_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	input  wire logic                          in_last,
	input  wire logic signed [COORD_WIDTH-1:0] pos [VEC_LEN],
	input  wire logic signed [COORD_WIDTH-1:0] nrm [VEC_LEN],
	output logic                               adv,
	pnr_out_if.source                          pt_out
);

	logic                          vld_q;
	logic                          last_q;
	logic signed [COORD_WIDTH-1:0] pos_q [VEC_LEN];
	logic signed [COORD_WIDTH-1:0] nrm_q [VEC_LEN];

	assign adv = !vld_q || pt_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			pos_q  <= pos;
			nrm_q  <= nrm;
			last_q <= in_last;
		end
	end

	assign pt_out.valid     = vld_q;
	assign pt_out.rot_pos_x = pos_q[0];
	assign pt_out.rot_pos_y = pos_q[1];
	assign pt_out.rot_pos_z = pos_q[2];
	assign pt_out.rot_nrm_x = nrm_q[0];
	assign pt_out.rot_nrm_y = nrm_q[1];
	assign pt_out.rot_nrm_z = nrm_q[2];
	assign pt_out.last_out  = last_q;

endmodule

`default_nettype wire

/* hdl/point_normal_rotate_xyz.sv */
// ----------------------------------------------------------------------------
// point_normal_rotate_xyz: Euler X-Y-Z rotation of a point and its normal
// Two parallel lanes (position, normal), six-stage pipeline, output register.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      carries
//   -------  ---  -------------  --------------------------------------------
//   pt_in    in   valid/ready    pos_x..z, nrm_x..z (Q12.12), last_in
//   pt_out   out  valid/ready    rot_pos_x..z, rot_nrm_x..z (saturated), last_out
//   cfg      in   valid/ready    index (register number), data (write value)
//
// One point request per cycle sustained while pt_out is ready. Per axis
// one multiply stage and one round/sum/saturate stage, then the output
// register. Each stage holds only while it is full and the one after it
// holds, so a stalled output does not stop bubbles from being filled.
// cfg is always ready; registers reset to all axes enabled, cos 1.0, sin 0.
// Reset clears the pipeline valid bits; data registers are not reset.
//
`default_nettype none

module point_normal_rotate_xyz import pnr_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	parameter int TRIG_WIDTH  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pnr_in_if.sink    pt_in,
	pnr_out_if.source pt_out,
	pnr_cfg_if.sink   cfg
);

	// ---------------- configuration registers ----------------
	localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE =
		{2'b01, {(TRIG_WIDTH-2){1'b0}}};

	logic [NUM_AXES-1:0]          axis_en_q;
	logic signed [TRIG_WIDTH-1:0] cos_q [NUM_AXES];
	logic signed [TRIG_WIDTH-1:0] sin_q [NUM_AXES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_en_q <= '1;
			for (int a = 0; a < NUM_AXES; a++) begin
				cos_q[a] <= TRIG_ONE;
				sin_q[a] <= '0;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_AXIS_EN: axis_en_q     <= cfg.data[NUM_AXES-1:0];
				REG_COS_X:   cos_q[AXIS_X] <= cfg.data;
				REG_SIN_X:   sin_q[AXIS_X] <= cfg.data;
				REG_COS_Y:   cos_q[AXIS_Y] <= cfg.data;
				REG_SIN_Y:   sin_q[AXIS_Y] <= cfg.data;
				REG_COS_Z:   cos_q[AXIS_Z] <= cfg.data;
				REG_SIN_Z:   sin_q[AXIS_Z] <= cfg.data;
				default:     ;   // index past the register list: dropped
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// vld_q[k] marks stage k full; a stage loads when empty or draining
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] last_q;
	pnr_ctl_t              ctl;
	logic                  merge_adv;

	always_comb begin
		ctl.adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || merge_adv;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ctl.adv[k] = !vld_q[k] || ctl.adv[k+1];
		end
	end

	assign pt_in.ready = ctl.adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.adv[0]) vld_q[0] <= pt_in.valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ctl.adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// end-of-shape flag rides alongside the lanes
	always_ff @(posedge clk) begin
		if (ctl.adv[0]) last_q[0] <= pt_in.last_in;
		for (int k = 1; k < NUM_STAGES; k++) begin
			if (ctl.adv[k]) last_q[k] <= last_q[k-1];
		end
	end

	// ---------------- lanes ----------------
	logic signed [COORD_WIDTH-1:0] pos_in  [VEC_LEN];
	logic signed [COORD_WIDTH-1:0] nrm_in  [VEC_LEN];
	logic signed [COORD_WIDTH-1:0] pos_rot [VEC_LEN];
	logic signed [COORD_WIDTH-1:0] nrm_rot [VEC_LEN];

	assign pos_in[0] = pt_in.pos_x;
	assign pos_in[1] = pt_in.pos_y;
	assign pos_in[2] = pt_in.pos_z;
	assign nrm_in[0] = pt_in.nrm_x;
	assign nrm_in[1] = pt_in.nrm_y;
	assign nrm_in[2] = pt_in.nrm_z;

	pnr_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.TRIG_WIDTH  (TRIG_WIDTH)
	) u_lane_pos (
		.clk     (clk),
		.ctl     (ctl),
		.axis_en (axis_en_q),
		.cos_v   (cos_q),
		.sin_v   (sin_q),
		.vec_in  (pos_in),
		.vec_out (pos_rot)
	);

	pnr_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.TRIG_WIDTH  (TRIG_WIDTH)
	) u_lane_nrm (
		.clk     (clk),
		.ctl     (ctl),
		.axis_en (axis_en_q),
		.cos_v   (cos_q),
		.sin_v   (sin_q),
		.vec_in  (nrm_in),
		.vec_out (nrm_rot)
	);

	// ---------------- merge / output register ----------------
	pnr_merge #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_q[NUM_STAGES-1]),
		.in_last (last_q[NUM_STAGES-1]),
		.pos     (pos_rot),
		.nrm     (nrm_rot),
		.adv     (merge_adv),
		.pt_out  (pt_out)
	);

endmodule

`default_nettype wire

/* test/point_normal_rotate_xyz_test.sv */
// ----------------------------------------------------------------------------
// point_normal_rotate_xyz_test: self-checking bench for the XYZ point rotator
// Drives points and register writes; checks results in order under random back-pressure
// against a prediction from a local register copy or a directed row's hand answer.
// ----------------------------------------------------------------------------
`default_nettype none

module point_normal_rotate_xyz_test;
	import pnr_pkg::*;

	localparam int CW = 24;
	localparam int TW = 16;
	localparam int TF = TW - 2;
	localparam int MAXC = (1 << (CW - 1)) - 1;
	localparam int MINC = -(1 << (CW - 1));
	// index past the register list: writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	// pipeline is seven deep; give it a little more before touching registers
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 16;
	localparam int PHASE_POINTS = 100;

	// one point (position, normal, end-of-shape flag); results share the layout
	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic signed [CW-1:0] nz;
		logic                 last;
	} point_t;

	typedef enum {ROW_WRITE, ROW_POINT} row_kind_e;

	// directed stimulus row: either a register write or a point
	typedef struct {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [TW-1:0]        data;
		point_t               pt;
		bit                   typed;  // want holds a hand-written answer
		point_t               want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pnr_in_if  #(.COORD_WIDTH(CW)) pt_in ();
	pnr_out_if #(.COORD_WIDTH(CW)) pt_out ();
	pnr_cfg_if #(.TRIG_WIDTH(TW))  cfg ();

	point_normal_rotate_xyz #(
		.COORD_WIDTH(CW),
		.TRIG_WIDTH (TW)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.pt_in (pt_in),
		.pt_out(pt_out),
		.cfg   (cfg)
	);

	always #1 clk = ~clk;

	// bench copy of the register file, updated on accepted writes
	logic [2:0]           axis_on;
	logic signed [TW-1:0] trig_val [6];  // cos_x, sin_x, cos_y, sin_y, cos_z, sin_z

	point_t    rotated_q [$];  // rotated points still owed by the block
	point_t    pending_rot;    // prediction for the point now on pt_in
	int        idle_pct;       // idle burst chance, per point sent and per receiver cycle
	int        bad_count;
	int        cycles;
	stim_row_t plan [$];

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Q2.14 product, rounded to nearest with ties going up
	function automatic longint round_mul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (TF - 1));
		return p >>> TF;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > MAXC)
			return MAXC;
		if (v < MINC)
			return MINC;
		return v;
	endfunction

	// planar turn of (u, v); each new component saturates on its own
	function automatic void turn_pair(inout longint u, inout longint v,
			input longint c, input longint s);
		longint nu;
		longint nv;
		nu = clamp_coord(round_mul(u, c) - round_mul(v, s));
		nv = clamp_coord(round_mul(u, s) + round_mul(v, c));
		u = nu;
		v = nv;
	endfunction

	// X, then Y, then Z; a cleared enable bit skips that axis for both vectors
	function automatic point_t rotate_point(point_t p);
		longint v [6];
		longint c;
		longint s;
		int     ax;
		int     b;
		point_t r;
		v[0] = $signed(p.px);
		v[1] = $signed(p.py);
		v[2] = $signed(p.pz);
		v[3] = $signed(p.nx);
		v[4] = $signed(p.ny);
		v[5] = $signed(p.nz);
		for (ax = 0; ax < NUM_AXES; ax++) begin
			if (axis_on[ax]) begin
				c = trig_val[2 * ax];
				s = trig_val[2 * ax + 1];
				for (b = 0; b < 6; b += VEC_LEN) begin
					case (ax)
						AXIS_X: turn_pair(v[b + 1], v[b + 2], c, s);
						AXIS_Y: turn_pair(v[b + 2], v[b], c, s);
						default: turn_pair(v[b], v[b + 1], c, s);
					endcase
				end
			end
		end
		r.px = v[0][CW-1:0];
		r.py = v[1][CW-1:0];
		r.pz = v[2][CW-1:0];
		r.nx = v[3][CW-1:0];
		r.ny = v[4][CW-1:0];
		r.nz = v[5][CW-1:0];
		r.last = p.last;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic point_t mk(int x, int y, int z, int a, int b, int c, bit last);
		point_t p;
		p.px = x[CW-1:0];
		p.py = y[CW-1:0];
		p.pz = z[CW-1:0];
		p.nx = a[CW-1:0];
		p.ny = b[CW-1:0];
		p.nz = c[CW-1:0];
		p.last = last;
		return p;
	endfunction

	function automatic stim_row_t wr_row(logic [CFG_IDX_W-1:0] idx, logic [TW-1:0] data);
		stim_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.pt = '0;
		r.typed = 0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t pt_row(point_t p);
		stim_row_t r;
		r.kind = ROW_POINT;
		r.idx = REG_AXIS_EN;
		r.data = '0;
		r.pt = p;
		r.typed = 0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(point_t p, point_t w);
		stim_row_t r;
		r = pt_row(p);
		r.typed = 1;
		r.want = w;
		return r;
	endfunction

	// small coordinates look like real meshes; the rest hit range and saturation
	function automatic logic [CW-1:0] rand_coord(int mode);
		int v;
		case (mode)
			0: v = int'($urandom_range(0, 524288)) - 262144;
			1: v = $urandom;
			2: begin
				case ($urandom_range(0, 4))
					0: v = MAXC;
					1: v = MINC;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			default: v = int'($urandom_range(0, 2097152)) - 1048576;
		endcase
		return v[CW-1:0];
	endfunction

	function automatic point_t random_point();
		int     mode;
		point_t p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mode = 0;
			4, 5, 6: mode = 1;
			7: mode = 2;
			default: mode = 3;
		endcase
		p.px = rand_coord(mode);
		p.py = rand_coord(mode);
		p.pz = rand_coord(mode);
		p.nx = rand_coord(mode);
		p.ny = rand_coord(mode);
		p.nz = rand_coord(mode);
		p.last = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	// mostly legal cos/sin values, some exact extremes, some raw bit patterns
	function automatic logic [TW-1:0] rand_trig();
		int v;
		case ($urandom_range(0, 3))
			0, 1: v = int'($urandom_range(0, 32768)) - 16384;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 16384;
					1: v = -16384;
					2: v = 0;
					default: v = 11585;  // ~0.7071
				endcase
			end
			default: v = $urandom;
		endcase
		return v[TW-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Drivers (all inputs change on the falling edge)
	// ------------------------------------------------------------------------

	// hold the point until the block takes it; valid stays up on return
	task automatic send_point(point_t p, point_t rot);
		pending_rot = rot;
		pt_in.pos_x = p.px;
		pt_in.pos_y = p.py;
		pt_in.pos_z = p.pz;
		pt_in.nrm_x = p.nx;
		pt_in.nrm_y = p.ny;
		pt_in.nrm_z = p.nz;
		pt_in.last_in = p.last;
		pt_in.valid = 1;
		do
			@(posedge clk);
		while (!pt_in.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TW-1:0] data);
		cfg.index = idx;
		cfg.data = data;
		cfg.valid = 1;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic sender_gap();
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			pt_in.valid = 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// stop sending, let every owed point come out, then let the pipe go quiet
	task automatic settle();
		pt_in.valid = 0;
		while (rotated_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random stall bursts on pt_out.ready
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		stall = 0;
		pt_out.ready = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				pt_out.ready = 0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				stall = $urandom_range(1, 15) - 1;
				pt_out.ready = 0;
			end else begin
				pt_out.ready = 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: register shadow, expected-result queue, in-order compare
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		point_t got;
		point_t want;
		if (arst_n) begin
			cycles++;
			if (cfg.valid && cfg.ready) begin
				// upper data bits beyond a register's width are dropped
				if (cfg.index == REG_AXIS_EN)
					axis_on = cfg.data[2:0];
				else if (cfg.index <= REG_SIN_Z)
					trig_val[cfg.index - 1] = cfg.data;
			end
			if (pt_in.valid && pt_in.ready)
				rotated_q.push_back(pending_rot);
			if (pt_out.valid && pt_out.ready) begin
				got = {pt_out.rot_pos_x, pt_out.rot_pos_y, pt_out.rot_pos_z,
					pt_out.rot_nrm_x, pt_out.rot_nrm_y, pt_out.rot_nrm_z, pt_out.last_out};
				if (rotated_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected point out: pos %0d %0d %0d nrm %0d %0d %0d last %0d",
							got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.last);
				end else begin
					want = rotated_q.pop_front();
					if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
							got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
							got.last !== want.last) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("mismatch at cycle %0d", cycles);
							$display("  want pos %0d %0d %0d nrm %0d %0d %0d last %0d",
								want.px, want.py, want.pz, want.nx, want.ny, want.nz, want.last);
							$display("  got  pos %0d %0d %0d nrm %0d %0d %0d last %0d",
								got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.last);
						end
					end
				end
			end
			// watchdog: a hung handshake ends the run here
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAIL point_normal_rotate_xyz");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int ph;
		int k;
		int i;
		point_t p;

		clk = 0;
		arst_n = 0;
		pt_in.valid = 0;
		pt_in.pos_x = '0;
		pt_in.pos_y = '0;
		pt_in.pos_z = '0;
		pt_in.nrm_x = '0;
		pt_in.nrm_y = '0;
		pt_in.nrm_z = '0;
		pt_in.last_in = 0;
		cfg.valid = 0;
		cfg.index = REG_AXIS_EN;
		cfg.data = '0;
		pending_rot = '0;
		idle_pct = 0;
		bad_count = 0;
		cycles = 0;
		// reset values: all axes on, cos 1.0, sin 0
		axis_on = 3'b111;
		for (i = 0; i < 6; i++)
			trig_val[i] = (i % 2 == 0) ? 16'sd16384 : 16'sd0;

		// directed table; rows with a hand answer skip the predictor
		// registers at reset rotate by zero, so points come back untouched
		plan.push_back(typed_row(mk(0, 0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0, 0)));
		plan.push_back(typed_row(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1),
			mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1)));
		plan.push_back(typed_row(mk(MINC, MINC, MINC, MINC, MINC, MINC, 0),
			mk(MINC, MINC, MINC, MINC, MINC, MINC, 0)));
		plan.push_back(typed_row(mk(MAXC, MINC, 1, -1, 4096, -4096, 1),
			mk(MAXC, MINC, 1, -1, 4096, -4096, 1)));
		// enable field sees only its low three bits: all axes off here
		plan.push_back(wr_row(REG_AXIS_EN, 16'hFFF8));
		plan.push_back(wr_row(REG_COS_X, 16'h1234));
		plan.push_back(typed_row(mk(123456, -654321, 7, -7, MAXC, MINC, 0),
			mk(123456, -654321, 7, -7, MAXC, MINC, 0)));
		// X only, cos -1.0: y and z flip sign, -min saturates to max
		plan.push_back(wr_row(REG_AXIS_EN, 16'h0001));
		plan.push_back(wr_row(REG_COS_X, 16'hC000));
		plan.push_back(wr_row(REG_SIN_X, 16'h0000));
		plan.push_back(typed_row(mk(100, MINC, MAXC, -5, 6, -7, 1),
			mk(100, MAXC, -MAXC, -5, -6, 7, 1)));
		// Y only, 90 degrees: x <- z, z <- -x
		plan.push_back(wr_row(REG_AXIS_EN, 16'h0002));
		plan.push_back(wr_row(REG_COS_Y, 16'h0000));
		plan.push_back(wr_row(REG_SIN_Y, 16'h4000));
		plan.push_back(typed_row(mk(1, 2, 3, 4096, 0, -4096, 0),
			mk(3, 2, -1, -4096, 0, -4096, 0)));
		// Z only, cos 0.5: half-LSB ties round up (0.5 -> 1, -0.5 -> 0)
		plan.push_back(wr_row(REG_AXIS_EN, 16'h0004));
		plan.push_back(wr_row(REG_COS_Z, 16'h2000));
		plan.push_back(wr_row(REG_SIN_Z, 16'h0000));
		plan.push_back(typed_row(mk(1, -1, 3, -1, 1, 5, 1), mk(1, 0, 3, 0, 1, 5, 1)));
		// trig beyond +-1.0 scales the vectors up: saturation on both lanes
		plan.push_back(wr_row(REG_COS_Z, 16'h7FFF));
		plan.push_back(wr_row(REG_SIN_Z, 16'h8000));
		plan.push_back(pt_row(mk(MAXC, MAXC, 1, MINC, MAXC, 0, 0)));
		plan.push_back(pt_row(mk(4096, -4096, 0, 1, 1, 1, 1)));
		// all three axes at once
		plan.push_back(wr_row(REG_AXIS_EN, 16'h0007));
		plan.push_back(wr_row(REG_COS_X, 16'h2D41));
		plan.push_back(wr_row(REG_SIN_X, 16'h2D41));
		plan.push_back(wr_row(REG_COS_Y, 16'hC000));
		plan.push_back(wr_row(REG_SIN_Y, 16'h4000));
		plan.push_back(wr_row(REG_COS_Z, 16'h4000));
		plan.push_back(wr_row(REG_SIN_Z, 16'hD2BF));
		plan.push_back(pt_row(mk(MAXC, MINC, MAXC, MINC, MAXC, MINC, 0)));
		plan.push_back(pt_row(mk(409600, -204800, 81920, 2896, 0, -2896, 1)));
		plan.push_back(pt_row(mk(-1, 1, -1, 1, -1, 1, 0)));
		// write to the spare index must leave every register alone
		plan.push_back(wr_row(REG_SPARE, 16'hFFFF));
		plan.push_back(pt_row(mk(8192, 16384, -24576, MAXC, 0, MINC, 1)));

		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				send_point(plan[r].pt,
					plan[r].typed ? plan[r].want : rotate_point(plan[r].pt));
			end
		end

		// random phases: new registers each phase, varying idle pressure,
		// the final phases run flat out
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph >= PHASES - 2) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 4))
					0: idle_pct = 0;
					1: idle_pct = 5;
					2: idle_pct = 15;
					3: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			end
			write_reg(REG_AXIS_EN, 16'(($urandom & 32'hFFF8) | $urandom_range(0, 7)));
			write_reg(REG_COS_X, rand_trig());
			write_reg(REG_SIN_X, rand_trig());
			write_reg(REG_COS_Y, rand_trig());
			write_reg(REG_SIN_Y, rand_trig());
			write_reg(REG_COS_Z, rand_trig());
			write_reg(REG_SIN_Z, rand_trig());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, 16'($urandom));
			for (k = 0; k < PHASE_POINTS; k++) begin
				// now and then hold off until the pipe has fully drained
				if (k == PHASE_POINTS / 2 && ph % 5 == 2)
					settle();
				sender_gap();
				p = random_point();
				send_point(p, rotate_point(p));
			end
		end

		settle();
		if (bad_count == 0)
			$display("PASS point_normal_rotate_xyz");
		else
			$display("FAIL point_normal_rotate_xyz");
		$finish;
	end

endmodule

`default_nettype wire
